// ----- hw/rtl/npif_pkg.sv -----
// Shared types and constants for the next present index finder.
// No dependencies; imported by every module of the block but npif_fifo.
package npif_pkg;

  // Fixed width of the index, found_index and size_in_use fields.
  localparam int IDX_W = 11;
  localparam int FUNC_W = 2;

  // Default geometry of the presence store.
  localparam int DEF_CAPACITY = 1024;
  localparam int DEF_WORD_BITS = 32;

  // Queue depths between front, back and result side.
  localparam int CMDQ_DEPTH = 2;
  localparam int RESQ_DEPTH = 2;

  // size_in_use after reset.
  localparam logic [IDX_W-1:0] CFG_SIZE_RESET = IDX_W'(1024);

  // Operation codes of the func field.
  localparam logic [FUNC_W-1:0] OP_QUERY   = 2'd0;
  localparam logic [FUNC_W-1:0] OP_REMOVE  = 2'd1;
  localparam logic [FUNC_W-1:0] OP_RESTART = 2'd2;

  // Classified command handed from front to back.
  typedef struct packed {
    logic [FUNC_W-1:0] op;
    logic              in_range;
    logic [IDX_W-1:0]  index;
  } cmd_t;

  // One result transaction.
  typedef struct packed {
    logic [IDX_W-1:0] found_index;
    logic             none_found;
  } res_t;

endpackage

// ----- hw/rtl/npif_fifo.sv -----
// Small register queue used for the command and result queues.
// Depends on nothing; width and depth come from the instantiating module.
module npif_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- hw/rtl/npif_front.sv -----
// Front end: accepts input transactions, classifies them and queues commands.
// Depends on npif_pkg and npif_fifo.
module npif_front
  import npif_pkg::*;
#(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [IDX_W-1:0]  size_in_use,
  input  logic              in_push,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [IDX_W-1:0]  in_index,
  output logic              in_full,
  input  logic              cmd_pop,
  output cmd_t              cmd,
  output logic              cmd_empty
);

  localparam int NWORDS     = CAPACITY / WORD_BITS + 1;
  localparam int TOTAL_BITS = NWORDS * WORD_BITS;
  localparam int WIDX_W     = $clog2(NWORDS);
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int ANS_W      = WIDX_W + BIT_W;
  localparam int CMP_W      = ((ANS_W > IDX_W) ? ANS_W : IDX_W) + 1;

  logic [CMP_W-1:0] index_ext;
  logic             below_total;
  logic             in_range;
  cmd_t             cmd_in;

  assign index_ext   = CMP_W'(in_index);
  assign below_total = (index_ext < CMP_W'(TOTAL_BITS));

  // Queries beyond storage and removes beyond the configured size do nothing.
  always_comb begin
    case (in_func)
      OP_QUERY:  in_range = below_total;
      OP_REMOVE: in_range = below_total && (in_index <= size_in_use);
      default:   in_range = 1'b0;
    endcase
  end

  assign cmd_in = '{op: in_func, in_range: in_range, index: in_index};

  npif_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (cmd_in),
    .full  (in_full),
    .pop   (cmd_pop),
    .rdata (cmd),
    .empty (cmd_empty)
  );

endmodule

// ----- hw/rtl/npif_back.sv -----
// Back end: presence word memory, summary bitmap and the query/remove engine.
// Depends on npif_pkg.
module npif_back
  import npif_pkg::*;
#(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] size_in_use,
  input  cmd_t             cmd,
  input  logic             cmd_empty,
  output logic             cmd_pop,
  input  logic             res_full,
  output logic             res_push,
  output res_t             res
);

  localparam int NWORDS = CAPACITY / WORD_BITS + 1;
  localparam int WIDX_W = $clog2(NWORDS);
  localparam int BIT_W  = $clog2(WORD_BITS);
  localparam int ANS_W  = WIDX_W + BIT_W;
  localparam int CMP_W  = ((ANS_W > IDX_W) ? ANS_W : IDX_W) + 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) pos = BIT_W'(i);
    end
    return pos;
  endfunction

  logic [WORD_BITS-1:0] mem [NWORDS];
  logic [NWORDS-1:0]    valid_r;
  logic [NWORDS-1:0]    summary_r;
  logic                 state_r, state_nxt;
  cmd_t                 cmd_r;
  logic [WIDX_W-1:0]    nxt_word_r;
  logic                 nxt_any_r;
  logic [WORD_BITS-1:0] rd0_r, rd1_r;
  logic                 v0_r, v1_r;

  logic                 start, exec;
  logic [CMP_W-1:0]     head_sh, cur_sh;
  logic [WIDX_W-1:0]    head_word, cur_word;
  logic [BIT_W-1:0]     cur_bit;
  logic [WIDX_W-1:0]    nxt_word;
  logic                 nxt_any;
  logic [WORD_BITS-1:0] word0, word1, tail, cleared;
  logic [ANS_W-1:0]     ans;
  logic                 hit;
  logic [CMP_W-1:0]     ans_ext;
  logic                 none;
  logic                 wr_en;

  assign start   = (state_r == ST_IDLE) && !cmd_empty && !res_full;
  assign exec    = (state_r == ST_EXEC);
  assign cmd_pop = start;

  // Word of the head command; out-of-range commands read word zero.
  assign head_sh   = CMP_W'(cmd.index) >> BIT_W;
  assign head_word = cmd.in_range ? head_sh[WIDX_W-1:0] : '0;

  // First non-empty word above the head command's word.
  always_comb begin
    nxt_word = '0;
    nxt_any  = 1'b0;
    for (int i = NWORDS - 1; i >= 0; i--) begin
      if (summary_r[i] && (WIDX_W'(i) > head_word)) begin
        nxt_word = WIDX_W'(i);
        nxt_any  = 1'b1;
      end
    end
  end

  assign cur_sh   = CMP_W'(cmd_r.index) >> BIT_W;
  assign cur_word = cmd_r.in_range ? cur_sh[WIDX_W-1:0] : '0;
  assign cur_bit  = cmd_r.index[BIT_W-1:0];

  // Words never written since restart read as all present.
  assign word0   = v0_r ? rd0_r : '1;
  assign word1   = v1_r ? rd1_r : '1;
  assign tail    = word0 & ({WORD_BITS{1'b1}} << cur_bit);
  assign cleared = word0 & ~(WORD_BITS'(1) << cur_bit);

  always_comb begin
    ans = '0;
    hit = 1'b0;
    if (tail != '0) begin
      ans = {cur_word, lowest_set(tail)};
      hit = 1'b1;
    end else if (nxt_any_r) begin
      ans = {nxt_word_r, lowest_set(word1)};
      hit = 1'b1;
    end
  end

  assign ans_ext = CMP_W'(ans);

  always_comb begin
    none = 1'b0;
    res  = '{found_index: cmd_r.index, none_found: 1'b0};
    if (cmd_r.op == OP_QUERY) begin
      none = !(cmd_r.in_range && hit && (ans_ext <= CMP_W'(size_in_use)));
      res  = '{found_index: none ? cmd_r.index : ans_ext[IDX_W-1:0], none_found: none};
    end
  end

  assign res_push = exec;
  assign wr_en    = exec && (cmd_r.op == OP_REMOVE) && cmd_r.in_range;

  always_comb begin
    case (state_r)
      ST_IDLE: state_nxt = start ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      valid_r   <= '0;
      summary_r <= '1;
    end else begin
      state_r <= state_nxt;
      if (exec && (cmd_r.op == OP_RESTART)) begin
        valid_r   <= '0;
        summary_r <= '1;
      end else if (wr_en) begin
        valid_r[cur_word] <= 1'b1;
        if (cleared == '0) begin
          summary_r[cur_word] <= 1'b0;
        end
      end
    end
  end

  // Two reads on start, one write on remove; never in the same cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      rd0_r <= mem[head_word];
      rd1_r <= mem[nxt_word];
    end
    if (wr_en) begin
      mem[cur_word] <= cleared;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cmd_r      <= cmd;
      nxt_word_r <= nxt_word;
      nxt_any_r  <= nxt_any;
      v0_r       <= valid_r[head_word];
      v1_r       <= valid_r[nxt_word];
    end
  end

endmodule

// ----- hw/rtl/next_present_index_finder.sv -----
// Top level of the next present index finder.
// Depends on npif_pkg, npif_front, npif_back and npif_fifo.
//
//   channel  direction  handshake           payload
//   in_      input      in_push / in_full   in_func, in_index
//   out_     output     out_pop / out_empty out_found_index, out_none_found
//   cfg_     input      cfg_wr_en           cfg_wr_data (size_in_use)
//
// In IDLE the back end reads the start word and the next non-empty word from
// the presence memory; in EXEC it resolves the answer or writes back a cleared
// word, and it takes no new command until it is back in IDLE. A result passes
// the command queue, the engine registers and the result queue on its way out.
// Reset marks every index present at once through per-word valid bits; no
// clearing pass. Command and result queues of two entries decouple the
// input side, the engine and the result side, so either port may stall.

module next_present_index_finder
  import npif_pkg::*;
#(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [IDX_W-1:0]  in_index,
  output logic              in_full,
  input  logic              out_pop,
  output logic              out_empty,
  output logic [IDX_W-1:0]  out_found_index,
  output logic              out_none_found,
  input  logic              cfg_wr_en,
  input  logic [IDX_W-1:0]  cfg_wr_data
);

  logic [IDX_W-1:0] size_in_use_r;
  cmd_t             cmd;
  logic             cmd_empty, cmd_pop;
  logic             res_full, res_push;
  res_t             res, res_head;

  // Hold the configured size; the user must write it only while the block is idle, which is not enforced.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_in_use_r <= CFG_SIZE_RESET;
    end else if (cfg_wr_en) begin
      size_in_use_r <= cfg_wr_data;
    end
  end

  // Accept and classify transactions.
  npif_front #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .size_in_use (size_in_use_r),
    .in_push     (in_push),
    .in_func     (in_func),
    .in_index    (in_index),
    .in_full     (in_full),
    .cmd_pop     (cmd_pop),
    .cmd         (cmd),
    .cmd_empty   (cmd_empty)
  );

  // Execute queries, removes and restarts.
  npif_back #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .size_in_use (size_in_use_r),
    .cmd         (cmd),
    .cmd_empty   (cmd_empty),
    .cmd_pop     (cmd_pop),
    .res_full    (res_full),
    .res_push    (res_push),
    .res         (res)
  );

  // Buffer results until the consumer pops them.
  npif_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RESQ_DEPTH)
  ) u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_head),
    .empty (out_empty)
  );

  assign out_found_index = res_head.found_index;
  assign out_none_found  = res_head.none_found;

endmodule

// ----- hw/rtl/npif_checker.sv -----
// Port-level checks for the next present index finder, bound to the top level.
// Depends on npif_pkg and next_present_index_finder.
module npif_port_checks
  import npif_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_push,
  input logic [FUNC_W-1:0] in_func,
  input logic [IDX_W-1:0]  in_index,
  input logic              in_full,
  input logic              out_pop,
  input logic              out_empty,
  input logic [IDX_W-1:0]  out_found_index,
  input logic              out_none_found,
  input logic              cfg_wr_en,
  input logic [IDX_W-1:0]  cfg_wr_data
);

  // Reset drops every pending result.
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // Reset frees the command queue.
  a_rst_not_full: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input side full after reset");

  // A waiting result holds until popped.
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_found_index) && $stable(out_none_found)))
    else $error("waiting result changed before pop");

  // An offered transaction carries a known payload.
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_push |-> !$isunknown({in_func, in_index}))
    else $error("unknown payload on offered transaction");

  // Write the size only with no result waiting and a known value.
  a_cfg_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |-> (out_empty && !$isunknown(cfg_wr_data)))
    else $error("size_in_use written with results in flight");

endmodule

bind next_present_index_finder npif_port_checks u_npif_port_checks (.*);

// ----- tb/npif_checker.sv -----
`timescale 1ns / 1ps
// Checker for the next present index finder: watches the input, result and
// size_in_use ports, predicts each result and compares it. Needs npif_pkg.
module npif_checker
  import npif_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic              in_full,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [IDX_W-1:0]  in_index,
  input  logic              out_pop,
  input  logic              out_empty,
  input  logic [IDX_W-1:0]  out_found_index,
  input  logic              out_none_found,
  input  logic              cfg_wr_en,
  input  logic [IDX_W-1:0]  cfg_wr_data,
  output int                fail_count,
  output int                pending,
  output int                result_count,
  output int                none_count
);

  localparam int WB     = DEF_WORD_BITS;
  localparam int NWORDS = DEF_CAPACITY / DEF_WORD_BITS + 1;
  localparam int SLOTS  = NWORDS * WB;

  logic [WB-1:0]     presence [NWORDS];
  logic [NWORDS-1:0] live_words;
  logic [IDX_W-1:0]  size_limit;
  res_t              answers_due [$];
  int                shown;

  function automatic void mark_all_present();
    for (int w = 0; w < NWORDS; w++) presence[w] = '1;
    live_words = '1;
  endfunction

  function automatic int first_set(logic [WB-1:0] v);
    for (int n = 0; n < WB; n++) if (v[n]) return n;
    return WB;
  endfunction

  // Smallest present slot at or above x, or -1 when there is none.
  function automatic int next_present(int x);
    int w;
    int b;
    logic [WB-1:0] t;
    if (x >= SLOTS) return -1;
    w = x / WB;
    b = x % WB;
    t = (presence[w] >> b) << b;
    if (t != '0) return w * WB + first_set(t);
    for (int k = w + 1; k < NWORDS; k++)
      if (live_words[k]) return k * WB + first_set(presence[k]);
    return -1;
  endfunction

  // Apply one operation to the predicted set and return its result.
  function automatic res_t apply_op(logic [FUNC_W-1:0] op, logic [IDX_W-1:0] x);
    res_t r;
    int hit;
    int w;
    r.found_index = x;
    r.none_found = 1'b0;
    case (op)
      OP_QUERY: begin
        hit = next_present(int'(x));
        if (hit >= 0 && hit <= int'(size_limit)) r.found_index = IDX_W'(hit);
        else r.none_found = 1'b1;
      end
      OP_REMOVE: begin
        if (x <= size_limit && int'(x) < SLOTS) begin
          w = int'(x) / WB;
          presence[w][int'(x) % WB] = 1'b0;
          if (presence[w] == '0) live_words[w] = 1'b0;
        end
      end
      OP_RESTART: mark_all_present();
      default: ;
    endcase
    return r;
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (shown < 10) begin
      shown++;
      $display("MISMATCH result %0d: %s", result_count, msg);
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      mark_all_present();
      size_limit = CFG_SIZE_RESET;
      answers_due.delete();
      fail_count = 0;
      result_count = 0;
      none_count = 0;
      shown = 0;
    end else begin
      if (out_pop && !out_empty) begin
        result_count++;
        if (out_none_found) none_count++;
        if (answers_due.size() == 0) begin
          note_failure($sformatf("unexpected transaction found_index %0d none_found %0b",
                                 out_found_index, out_none_found));
        end else begin
          want = answers_due.pop_front();
          if (out_found_index !== want.found_index)
            note_failure($sformatf("found_index expected %0d actual %0d",
                                   want.found_index, out_found_index));
          if (out_none_found !== want.none_found)
            note_failure($sformatf("none_found expected %0b actual %0b",
                                   want.none_found, out_none_found));
        end
      end
      if (cfg_wr_en) size_limit = cfg_wr_data;
      if (in_push && !in_full) answers_due.push_back(apply_op(in_func, in_index));
    end
    pending = answers_due.size();
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench top for next_present_index_finder: clock, reset, stimulus and
// verdict. Needs npif_pkg, the block and npif_checker.
module tb_top;
  import npif_pkg::*;

  // The func code the block leaves unused; it must act as a no-op.
  localparam logic [FUNC_W-1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 2000;
  localparam int IDLE_LIMIT   = 1000;
  localparam int SLOTS        = (DEF_CAPACITY / DEF_WORD_BITS + 1) * DEF_WORD_BITS;
  localparam int IDX_MAX      = (1 << IDX_W) - 1;

  // Stall patterns of the result side, picked at random by the pop process.
  typedef enum int {POP_ALWAYS, POP_TWO_OF_THREE, POP_COIN, POP_LONG_STALL} pop_mode_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_push = 1'b0;
  logic [FUNC_W-1:0] in_func = OP_QUERY;
  logic [IDX_W-1:0]  in_index = '0;
  logic              in_full;
  logic              out_pop = 1'b0;
  logic              out_empty;
  logic [IDX_W-1:0]  out_found_index;
  logic              out_none_found;
  logic              cfg_wr_en = 1'b0;
  logic [IDX_W-1:0]  cfg_wr_data = '0;

  int fail_count;
  int pending;
  int result_count;
  int none_count;

  int        idle_cycles = 0;
  int        burst_left = 0;
  int        size_writes = 0;
  int        items_sent = 0;
  int        pop_cycle = 0;
  pop_mode_t pop_mode = POP_ALWAYS;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  next_present_index_finder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_func         (in_func),
    .in_index        (in_index),
    .in_full         (in_full),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_found_index (out_found_index),
    .out_none_found  (out_none_found),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  npif_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_func         (in_func),
    .in_index        (in_index),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_found_index (out_found_index),
    .out_none_found  (out_none_found),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .fail_count      (fail_count),
    .pending         (pending),
    .result_count    (result_count),
    .none_count      (none_count)
  );

  // Result side: pop on a randomly picked pattern, from no stalls at all
  // (POP_ALWAYS) to runs of stalled cycles (POP_LONG_STALL).
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      pop_cycle <= 0;
    end else begin
      pop_cycle <= pop_cycle + 1;
      if (pop_cycle % 128 == 0) pop_mode <= pop_mode_t'($urandom_range(0, 3));
      case (pop_mode)
        POP_ALWAYS:       out_pop <= 1'b1;
        POP_TWO_OF_THREE: out_pop <= (pop_cycle % 3) != 0;
        POP_COIN:         out_pop <= 1'($urandom_range(0, 1));
        default:          out_pop <= (pop_cycle % 32) >= 20;
      endcase
    end
  end

  // Watchdog: end the run when no transaction moves on either side for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[next_present_index_finder] ERROR");
        $finish;
      end
    end
  end

  // Offer one transaction and hold it until accepted. Sample in_full at the
  // falling edge so the decision never races the block's own update. Push
  // stays high into the next call unless the burst ends here with an idle gap.
  task automatic push_item(input logic [FUNC_W-1:0] op, input logic [IDX_W-1:0] idx);
    int gap;
    in_push <= 1'b1;
    in_func <= op;
    in_index <= idx;
    @(negedge clk);
    while (in_full) @(negedge clk);
    @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // End of a burst: pick the next burst length and idle for a random gap.
      gap = $urandom_range(0, 6);
      burst_left = $urandom_range(0, 24);
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drop push and hold off until every expected result has been popped.
  task automatic drain();
    in_push <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Write size_in_use; call only with the block idle.
  task automatic write_size(input logic [IDX_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    size_writes++;
  endtask

  // Random traffic. Most of it removes or queries around a focus window so that
  // whole words empty out and queries must skip ahead through the summary; the rest
  // sweeps contiguous runs, restarts, uses the dead func code or is noise over
  // the whole index range.
  task automatic random_traffic(input int count);
    int n;
    int pick;
    int focus;
    int base;
    int len;
    int lo;
    n = 0;
    focus = $urandom_range(0, SLOTS - 1);
    while (n < count) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 49) == 0)
        focus = $urandom_range(0, 1) ? $urandom_range(0, 64) : $urandom_range(0, SLOTS - 1);
      if (pick < 12) begin
        // Sweep: clear a run, then probe just below, inside and past it.
        len = $urandom_range(1, 80);
        base = $urandom_range(0, 1) ? focus : $urandom_range(0, SLOTS - 1);
        for (int k = 0; k < len && n < count; k++) begin
          push_item(OP_REMOVE, IDX_W'(base + k));
          n++;
        end
        lo = (base >= 3) ? base - 3 : 0;
        for (int k = 0; k < 4 && n < count; k++) begin
          push_item(OP_QUERY, IDX_W'(lo + $urandom_range(0, len + 6)));
          n++;
        end
      end else if (pick < 70) begin
        push_item($urandom_range(0, 99) < 55 ? OP_REMOVE : OP_QUERY,
                  IDX_W'(focus + $urandom_range(0, 63)));
        n++;
      end else if (pick < 72) begin
        push_item(OP_RESTART, IDX_W'($urandom_range(0, IDX_MAX)));
        n++;
      end else if (pick < 75) begin
        push_item(OP_UNUSED, IDX_W'($urandom_range(0, IDX_MAX)));
        n++;
      end else begin
        push_item(FUNC_W'($urandom_range(0, 3)), IDX_W'($urandom_range(0, IDX_MAX)));
        n++;
      end
      // Now and then hold the sender until the block has fully drained.
      if ($urandom_range(0, 99) == 0) drain();
    end
  endtask

  initial begin
    int sizes [8];
    sizes = '{IDX_MAX, 0, 1, 31, 32, SLOTS - 1, DEF_CAPACITY, 0};
    sizes[7] = $urandom_range(0, IDX_MAX);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, size_in_use still at its reset value.
    push_item(OP_QUERY, IDX_W'(0));
    push_item(OP_QUERY, IDX_W'(DEF_CAPACITY));       // last index inside the size
    push_item(OP_QUERY, IDX_W'(DEF_CAPACITY + 1));   // present but beyond the size
    push_item(OP_QUERY, IDX_W'(SLOTS));              // beyond the storage
    push_item(OP_QUERY, IDX_W'(IDX_MAX));
    push_item(OP_REMOVE, IDX_W'(0));
    push_item(OP_QUERY, IDX_W'(0));                  // skip to index 1
    push_item(OP_REMOVE, IDX_W'(0));                 // already absent
    push_item(OP_REMOVE, IDX_W'(DEF_CAPACITY));
    push_item(OP_QUERY, IDX_W'(DEF_CAPACITY - 24));
    push_item(OP_QUERY, IDX_W'(DEF_CAPACITY));       // answer lies past the size
    push_item(OP_REMOVE, IDX_W'(DEF_CAPACITY + 1));  // above the size: ignored
    push_item(OP_REMOVE, IDX_W'(IDX_MAX));           // beyond storage: ignored
    push_item(OP_UNUSED, IDX_W'(IDX_MAX));
    push_item(OP_UNUSED, IDX_W'(0));
    push_item(OP_RESTART, IDX_W'(1234));
    push_item(OP_QUERY, IDX_W'(0));
    push_item(OP_QUERY, IDX_W'(DEF_CAPACITY));
    drain();

    // Random phases, each under its own size_in_use, extremes included.
    // Draining before each write keeps the register change off any
    // transaction in flight.
    foreach (sizes[i]) begin
      write_size(IDX_W'(sizes[i]));
      random_traffic(RANDOM_ITEMS / 8);
      drain();
    end

    // Settle: let the pipeline latency pass so any stray result shows up.
    repeat (12) @(posedge clk);
    @(negedge clk);

    $display("Run covered %0d transactions in, %0d results checked (%0d with no answer),",
             items_sent, result_count, none_count);
    $display("under %0d size_in_use settings from 0 to %0d.", size_writes, IDX_MAX);
    if (fail_count == 0 && pending == 0) begin
      $display("[next_present_index_finder] OK");
    end else begin
      $display("[next_present_index_finder] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/npif_pkg.sv
hw/rtl/npif_fifo.sv
hw/rtl/npif_front.sv
hw/rtl/npif_back.sv
hw/rtl/next_present_index_finder.sv
hw/rtl/npif_checker.sv
tb/npif_checker.sv
tb/tb_top.sv
